// ===== design/kmd_pkg.sv =====
// Shared types and constants for the key matrix debouncer.
package kmd_pkg;

    localparam int unsigned LEVELS_W    = 64;
    localparam int unsigned THR_W       = 8;
    localparam int unsigned POS_W       = 3;
    localparam logic [THR_W-1:0] THR_RESET = 8'd5;

    // Event queue between the scanner and the output stage
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    // One queue word: an event, an end-of-scan mark, or both
    typedef struct packed {
        logic             fire;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             down;
        logic             eos;
    } t_evt_entry;

    // Stored per key: pressed flag and debounce count
    typedef struct packed {
        logic             pressed;
        logic [THR_W-1:0] count;
    } t_key_word;

endpackage

// ===== design/kmd_if.sv =====
// Valid/ready channel interfaces for scan words and event words.
interface kmd_scan_if;
    logic                               valid;
    logic                               ready;
    logic [kmd_pkg::LEVELS_W-1:0]       key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink   (input valid, input key_levels, output ready);
endinterface

interface kmd_event_if;
    logic                               valid;
    logic                               ready;
    logic [kmd_pkg::POS_W-1:0]          event_col;
    logic [kmd_pkg::POS_W-1:0]          event_row;
    logic                               key_down;
    logic                               last_event;

    modport source (output valid, output event_col, output event_row,
                    output key_down, output last_event, input ready);
    modport sink   (input valid, input event_col, input event_row,
                    input key_down, input last_event, output ready);
endinterface

// ===== design/kmd_scan.sv =====
// Scanner: walks every key of a scan word, updates its counter and flag, queues events.
module kmd_scan #(
    parameter int unsigned NUM_COLS = 8,
    parameter int unsigned NUM_ROWS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [kmd_pkg::THR_W-1:0]      i_threshold,
    kmd_scan_if.sink                       i_scan,
    output logic                           o_push,
    output kmd_pkg::t_evt_entry            o_entry,
    input  logic                           i_full
);

    localparam int unsigned NUM_KEYS = NUM_COLS * NUM_ROWS;
    localparam int unsigned KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                          r_state, n_state;
    logic [KEY_W-1:0]                r_key, n_key;
    logic [kmd_pkg::POS_W-1:0]       r_col, n_col;
    logic [kmd_pkg::POS_W-1:0]       r_row, n_row;
    logic [NUM_KEYS-1:0]             r_levels, n_levels;
    logic [NUM_KEYS-1:0]             r_vld;
    logic                            r_rd_vld;
    kmd_pkg::t_key_word              r_rd_word;
    kmd_pkg::t_key_word              r_mem [NUM_KEYS];

    kmd_pkg::t_key_word              cur, upd;
    logic                            fire, dir, last_key, need_push, advance;
    logic                            rd_en, wr_en;
    logic [KEY_W-1:0]                rd_addr;

    always_comb begin
        cur = r_rd_vld ? r_rd_word : '0;
        upd = cur;
        fire = 1'b0;
        dir = 1'b0;
        if (!cur.pressed && r_levels[0] && (cur.count < i_threshold)) begin
            upd.count = cur.count + 1'b1;
            if (upd.count == i_threshold) begin
                upd.pressed = 1'b1;
                fire = 1'b1;
                dir = 1'b1;
            end
        end else if (cur.pressed && !r_levels[0] && (cur.count != '0)) begin
            upd.count = cur.count - 1'b1;
            if (upd.count == '0) begin
                upd.pressed = 1'b0;
                fire = 1'b1;
            end
        end
    end

    assign last_key  = (r_key == KEY_W'(NUM_KEYS - 1));
    assign need_push = (r_state == S_RUN) && (fire || last_key);
    // Stall on a full queue only when this key has something to queue
    assign advance   = (r_state == S_RUN) && (!need_push || !i_full);

    assign o_push        = need_push && !i_full;
    assign o_entry.fire  = fire;
    assign o_entry.col   = r_col;
    assign o_entry.row   = r_row;
    assign o_entry.down  = dir;
    assign o_entry.eos   = last_key;

    assign i_scan.ready  = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_key    = r_key;
        n_col    = r_col;
        n_row    = r_row;
        n_levels = r_levels;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_scan.valid) begin
                    n_state  = S_RUN;
                    n_key    = '0;
                    n_col    = '0;
                    n_row    = '0;
                    n_levels = i_scan.key_levels[NUM_KEYS-1:0];
                    rd_en    = 1'b1;
                end
            end
            S_RUN: begin
                if (advance) begin
                    wr_en = 1'b1;
                    if (last_key) begin
                        n_state = S_IDLE;
                    end else begin
                        n_key    = r_key + 1'b1;
                        n_levels = r_levels >> 1;
                        rd_en    = 1'b1;
                        rd_addr  = r_key + 1'b1;
                        if (r_row == kmd_pkg::POS_W'(NUM_ROWS - 1)) begin
                            n_row = '0;
                            n_col = r_col + 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_vld[r_key] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
        end
        r_key    <= n_key;
        r_col    <= n_col;
        r_row    <= n_row;
        r_levels <= n_levels;
    end

    // Key store: write the current key, read the next one in the same cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_key] <= upd;
        end
        if (rd_en) begin
            r_rd_word <= r_mem[rd_addr];
        end
    end

endmodule

// ===== design/kmd_fifo.sv =====
// Short event queue between the scanner and the output stage.
module kmd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  kmd_pkg::t_evt_entry  i_entry,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output kmd_pkg::t_evt_entry  o_entry
);

    kmd_pkg::t_evt_entry              r_data [kmd_pkg::QUEUE_DEPTH];
    logic [kmd_pkg::QPTR_W-1:0]       r_wr_ptr, r_rd_ptr;
    logic [kmd_pkg::QCNT_W-1:0]       r_count;
    logic                             do_pop;

    assign o_full  = (r_count == kmd_pkg::QCNT_W'(kmd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_data[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_data[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== design/kmd_emit.sv =====
// Output stage: holds back one event so the final one of a scan can be marked last.
module kmd_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  kmd_pkg::t_evt_entry  i_q_entry,
    output logic                 o_pop,
    kmd_event_if.source          o_event
);

    kmd_pkg::t_evt_entry  r_hold, n_hold;
    logic                 r_hold_vld, n_hold_vld;
    logic                 r_out_vld;
    logic [kmd_pkg::POS_W-1:0] r_out_col, r_out_row;
    logic                 r_out_down, r_out_last;
    logic                 out_free, emit, emit_last;

    assign out_free = !r_out_vld || o_event.ready;

    always_comb begin
        n_hold     = r_hold;
        n_hold_vld = r_hold_vld;
        o_pop      = 1'b0;
        emit       = 1'b0;
        emit_last  = 1'b0;
        if (r_hold_vld && r_hold.eos) begin
            // Held word closes its scan: drain it before taking more
            if (out_free) begin
                emit       = 1'b1;
                emit_last  = 1'b1;
                n_hold_vld = 1'b0;
            end
        end else if (i_q_valid && (!r_hold_vld || out_free)) begin
            o_pop = 1'b1;
            emit  = r_hold_vld;
            if (i_q_entry.fire) begin
                n_hold     = i_q_entry;
                n_hold_vld = 1'b1;
            end else begin
                // Bare end mark: the held event, if any, was the last one
                emit_last  = 1'b1;
                n_hold_vld = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_hold_vld <= n_hold_vld;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (o_event.ready) begin
                r_out_vld <= 1'b0;
            end
        end
        r_hold <= n_hold;
        if (emit) begin
            r_out_col  <= r_hold.col;
            r_out_row  <= r_hold.row;
            r_out_down <= r_hold.down;
            r_out_last <= emit_last;
        end
    end

    assign o_event.valid      = r_out_vld;
    assign o_event.event_col  = r_out_col;
    assign o_event.event_row  = r_out_row;
    assign o_event.key_down   = r_out_down;
    assign o_event.last_event = r_out_last;

endmodule

// ===== design/key_matrix_debouncer_core.sv =====
// Key matrix debouncer top level: scanner, event queue and output stage.
//
// i_scan takes one scan word per debounce tick: bit col*NUM_ROWS+row is the
// raw level of that key, 1 means down. o_event gives one word per debounced
// press or release, in column-major key order, with last_event set on the
// final word of a scan; a quiet scan gives no word at all.
// i_cfg_we/i_cfg_wdata set the debounce threshold (scan count to accept a
// change); write it only while the block is idle.
// A scan occupies the scanner to take the word and fetch the first key, then
// one key per cycle unless a key that must queue a word meets a full queue,
// via the key store, which writes a key and reads the next in the same cycle.
// i_scan.ready is high only while the scanner is idle.
// Events pass a 4-word queue, a hold register and the output register to
// o_event; the last event of a scan leaves once its end mark is seen.
// When the receiver stalls, the output register holds, the queue fills and
// the scanner stops on the next key that has to queue a word.
// Reset clears every counter and pressed flag at once (per-key valid bits),
// the queue and the output, and sets the threshold to 5.
module key_matrix_debouncer_core #(
    parameter int unsigned NUM_COLS = 8,
    parameter int unsigned NUM_ROWS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [kmd_pkg::THR_W-1:0]  i_cfg_wdata,
    kmd_scan_if.sink                   i_scan,
    kmd_event_if.source                o_event
);

    logic [kmd_pkg::THR_W-1:0]  r_threshold;
    logic                       push, full, pop, q_valid;
    kmd_pkg::t_evt_entry        push_entry, q_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= kmd_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    kmd_scan #(
        .NUM_COLS (NUM_COLS),
        .NUM_ROWS (NUM_ROWS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_scan      (i_scan),
        .o_push      (push),
        .o_entry     (push_entry),
        .i_full      (full)
    );

    kmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    kmd_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .o_event   (o_event)
    );

endmodule

// ===== design/kmd_checker.sv =====
// Port-level checks for the key matrix debouncer, bound to the top level.
module kmd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_scan_valid,
    input logic                       i_scan_ready,
    input logic                       i_ev_valid,
    input logic                       i_ev_ready,
    input logic [kmd_pkg::POS_W-1:0]  i_ev_col,
    input logic [kmd_pkg::POS_W-1:0]  i_ev_row,
    input logic                       i_ev_down,
    input logic                       i_ev_last
);

    // Hold an offered event until taken
    a_ev_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ev_valid && !i_ev_ready |=> i_ev_valid)
        else $error("event word dropped while stalled");

    a_ev_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ev_valid && !i_ev_ready |=>
            $stable(i_ev_col) && $stable(i_ev_row) && $stable(i_ev_down) &&
            $stable(i_ev_last))
        else $error("event word changed while stalled");

    // A scan keeps the scanner busy past its accepting cycle
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_scan_valid && i_scan_ready |=> !i_scan_ready)
        else $error("scanner took two scan words back to back");

    // Reset drops any pending event word
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_ev_valid)
        else $error("event word valid right after reset");

endmodule

bind key_matrix_debouncer_core kmd_checker u_kmd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_scan_valid (i_scan.valid),
    .i_scan_ready (i_scan.ready),
    .i_ev_valid   (o_event.valid),
    .i_ev_ready   (o_event.ready),
    .i_ev_col     (o_event.event_col),
    .i_ev_row     (o_event.event_row),
    .i_ev_down    (o_event.key_down),
    .i_ev_last    (o_event.last_event)
);
